>>> hdl/lacqd_pkg.sv
package lacqd_pkg;

  // queue storage
  localparam int unsigned MaxQueues = 16;
  localparam int unsigned QIdxW     = $clog2(MaxQueues);

  // field widths
  localparam int unsigned CpuW   = 8;
  localparam int unsigned CountW = 5;
  localparam int unsigned LoadW  = 32;
  localparam int unsigned BytesW = 24;
  localparam int unsigned CmdW   = 2;

  // cpu number at full width: base plus largest index times stride
  localparam int unsigned ProdW    = QIdxW + CpuW;
  localparam int unsigned CpuFullW = ProdW + 1;

  // shared divider operand width
  localparam int unsigned DivW   = 8;
  localparam int unsigned DivCntW = $clog2(DivW);

  // register file
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;
  localparam int unsigned RegIdxW = 2;

  localparam logic [RegIdxW-1:0] RegBaseCore  = 2'd0;
  localparam logic [RegIdxW-1:0] RegStride    = 2'd1;
  localparam logic [RegIdxW-1:0] RegCount     = 2'd2;
  localparam logic [RegIdxW-1:0] RegThreshold = 2'd3;

  localparam logic [LoadW-1:0] ThreshReset = LoadW'(10 * 65536);
  localparam logic [LoadW-1:0] LoadMax     = '1;

  // request commands
  localparam logic [CmdW-1:0] CmdEnqueue  = 2'd0;
  localparam logic [CmdW-1:0] CmdComplete = 2'd1;
  localparam logic [CmdW-1:0] CmdRrPick   = 2'd2;
  localparam logic [CmdW-1:0] CmdCompact  = 2'd3;

  typedef struct packed {
    logic [CpuW-1:0]   base_core;
    logic [CpuW-1:0]   core_stride;
    logic [CountW-1:0] queue_count;
    logic [LoadW-1:0]  load_threshold;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
    logic [DivW-1:0] rem;
  } div_rsp_t;

endpackage

>>> hdl/lacqd_cfg.sv
module lacqd_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lacqd_pkg::AddrW-1:0]       paddr,
  input  logic [lacqd_pkg::DataW-1:0]       pwdata,
  output logic [lacqd_pkg::DataW-1:0]       prdata,
  output logic                              pready,
  output lacqd_pkg::cfg_t                   cfg_o
);

  lacqd_pkg::cfg_t                    cfg_q, cfg_d;
  logic                               wr_en;
  logic [lacqd_pkg::RegIdxW-1:0]      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[lacqd_pkg::AddrW-1:2];
  assign wr_en   = psel & penable & pwrite;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        lacqd_pkg::RegBaseCore:  cfg_d.base_core      = pwdata[lacqd_pkg::CpuW-1:0];
        lacqd_pkg::RegStride:    cfg_d.core_stride    = pwdata[lacqd_pkg::CpuW-1:0];
        lacqd_pkg::RegCount:     cfg_d.queue_count    = pwdata[lacqd_pkg::CountW-1:0];
        lacqd_pkg::RegThreshold: cfg_d.load_threshold = pwdata[lacqd_pkg::LoadW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_core      <= '0;
      cfg_q.core_stride    <= lacqd_pkg::CpuW'(1);
      cfg_q.queue_count    <= lacqd_pkg::CountW'(1);
      cfg_q.load_threshold <= lacqd_pkg::ThreshReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      lacqd_pkg::RegBaseCore:  prdata = lacqd_pkg::DataW'(cfg_q.base_core);
      lacqd_pkg::RegStride:    prdata = lacqd_pkg::DataW'(cfg_q.core_stride);
      lacqd_pkg::RegCount:     prdata = lacqd_pkg::DataW'(cfg_q.queue_count);
      lacqd_pkg::RegThreshold: prdata = lacqd_pkg::DataW'(cfg_q.load_threshold);
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/lacqd_div.sv
module lacqd_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lacqd_pkg::div_req_t req_i,
  output lacqd_pkg::div_rsp_t rsp_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [lacqd_pkg::DivCntW-1:0]    cnt_q, cnt_d;
  logic [lacqd_pkg::DivW-1:0]       rem_q, rem_d;
  logic [lacqd_pkg::DivW-1:0]       quo_q, quo_d;
  logic [lacqd_pkg::DivW-1:0]       dvs_q, dvs_d;
  logic [lacqd_pkg::DivW:0]         shifted;
  logic [lacqd_pkg::DivW:0]         trial;
  logic                             ge;

  // one restoring step per cycle
  assign shifted = {rem_q, quo_q[lacqd_pkg::DivW-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? trial[lacqd_pkg::DivW-1:0] : shifted[lacqd_pkg::DivW-1:0];
      quo_d = {quo_q[lacqd_pkg::DivW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == lacqd_pkg::DivCntW'(lacqd_pkg::DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> hdl/lacqd_seq.sv
module lacqd_seq (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lacqd_pkg::cfg_t                    cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [lacqd_pkg::CmdW-1:0]         command_i,
  input  logic [lacqd_pkg::CpuW-1:0]         last_cpu_i,
  input  logic [lacqd_pkg::CpuW-1:0]         current_cpu_i,
  input  logic [lacqd_pkg::QIdxW-1:0]        queue_index_i,
  input  logic [lacqd_pkg::BytesW-1:0]       byte_count_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [lacqd_pkg::CpuW-1:0]         chosen_cpu_o,
  output logic                               found_o,
  output logic [lacqd_pkg::LoadW-1:0]        queue_load_o,
  output logic                               underflow_o,
  output lacqd_pkg::div_req_t                div_req_o,
  input  lacqd_pkg::div_rsp_t                div_rsp_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv1 = 3'd1;
  localparam logic [2:0] StDiv2 = 3'd2;
  localparam logic [2:0] StScan = 3'd3;
  localparam logic [2:0] StPush = 3'd4;

  logic [2:0]                        state_q, state_d;
  logic                              rr_q, rr_d;
  logic [lacqd_pkg::CpuW-1:0]        cur_q, cur_d;
  logic [lacqd_pkg::QIdxW-1:0]       q_q, q_d;
  logic [lacqd_pkg::QIdxW-1:0]       steps_q, steps_d;

  logic [lacqd_pkg::CpuW-1:0]        res_cpu_q, res_cpu_d;
  logic                              res_found_q, res_found_d;
  logic [lacqd_pkg::LoadW-1:0]       res_load_q, res_load_d;
  logic                              res_under_q, res_under_d;

  logic                              out_valid_q, out_valid_d;
  logic [lacqd_pkg::CpuW-1:0]        out_cpu_q;
  logic                              out_found_q;
  logic [lacqd_pkg::LoadW-1:0]       out_load_q;
  logic                              out_under_q;
  logic                              out_load_en;

  logic [lacqd_pkg::LoadW-1:0]       load_mem_q [lacqd_pkg::MaxQueues];
  logic                              mem_we;
  logic [lacqd_pkg::LoadW-1:0]       mem_wdata;
  logic [lacqd_pkg::QIdxW-1:0]       rd_addr;
  logic [lacqd_pkg::LoadW-1:0]       rd_load;

  logic [lacqd_pkg::CpuW-1:0]        stride_eff;
  logic [lacqd_pkg::CountW-1:0]      n_eff;
  logic [lacqd_pkg::ProdW-1:0]       cpu_prod;
  logic [lacqd_pkg::CpuFullW-1:0]    cpu_full;
  logic                              below;
  logic                              hit;
  logic                              last_step;
  logic [lacqd_pkg::LoadW:0]         enq_sum;
  logic [lacqd_pkg::LoadW-1:0]       bytes_ext;
  logic                              cpl_under;
  logic [lacqd_pkg::CpuW-1:0]        diff;

  // next index in cyclic order over the queues in use
  function automatic logic [lacqd_pkg::QIdxW-1:0] next_idx(
    input logic [lacqd_pkg::QIdxW-1:0]  idx,
    input logic [lacqd_pkg::CountW-1:0] cnt
  );
    logic [lacqd_pkg::CountW-1:0] inc;
    inc = {1'b0, idx} + 1'b1;
    return (inc == cnt) ? '0 : inc[lacqd_pkg::QIdxW-1:0];
  endfunction

  // effective configuration
  assign stride_eff = (cfg_i.core_stride == '0) ? lacqd_pkg::CpuW'(1) : cfg_i.core_stride;
  assign n_eff = (cfg_i.queue_count > lacqd_pkg::CountW'(lacqd_pkg::MaxQueues))
                 ? lacqd_pkg::CountW'(lacqd_pkg::MaxQueues) : cfg_i.queue_count;

  // single counter read port
  assign rd_addr = (state_q == StIdle) ? queue_index_i : q_q;
  assign rd_load = load_mem_q[rd_addr];

  // cpu number and threshold test of the scanned queue
  assign cpu_prod  = lacqd_pkg::ProdW'(q_q) * lacqd_pkg::ProdW'(stride_eff);
  assign cpu_full  = lacqd_pkg::CpuFullW'(cfg_i.base_core) + lacqd_pkg::CpuFullW'(cpu_prod);
  assign below     = rd_load < cfg_i.load_threshold;
  assign hit       = below && (!rr_q || (cpu_full != lacqd_pkg::CpuFullW'(cur_q)));
  assign last_step = ({1'b0, steps_q} == (n_eff - 1'b1));

  // enqueue and complete arithmetic
  assign bytes_ext = lacqd_pkg::LoadW'(byte_count_i);
  assign enq_sum   = {1'b0, rd_load} + {1'b0, bytes_ext};
  assign cpl_under = bytes_ext > rd_load;
  assign diff      = last_cpu_i - cfg_i.base_core;

  assign in_ready_o = (state_q == StIdle);

  // sequencer
  always_comb begin
    state_d     = state_q;
    rr_d        = rr_q;
    cur_d       = cur_q;
    q_d         = q_q;
    steps_d     = steps_q;
    res_cpu_d   = res_cpu_q;
    res_found_d = res_found_q;
    res_load_d  = res_load_q;
    res_under_d = res_under_q;
    mem_we      = 1'b0;
    mem_wdata   = rd_load;
    div_req_o   = '0;
    out_load_en = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          res_cpu_d   = '0;
          res_found_d = 1'b0;
          res_load_d  = '0;
          res_under_d = 1'b0;
          case (command_i)
            lacqd_pkg::CmdEnqueue: begin
              mem_we     = 1'b1;
              mem_wdata  = enq_sum[lacqd_pkg::LoadW] ? lacqd_pkg::LoadMax
                                                      : enq_sum[lacqd_pkg::LoadW-1:0];
              res_load_d = mem_wdata;
              state_d    = StPush;
            end
            lacqd_pkg::CmdComplete: begin
              mem_we      = 1'b1;
              mem_wdata   = cpl_under ? '0 : rd_load - bytes_ext;
              res_load_d  = mem_wdata;
              res_under_d = cpl_under;
              state_d     = StPush;
            end
            lacqd_pkg::CmdRrPick: begin
              rr_d  = 1'b1;
              cur_d = current_cpu_i;
              if (n_eff == '0) begin
                state_d = StPush;
              end else begin
                div_req_o.start    = 1'b1;
                div_req_o.dividend = (last_cpu_i > cfg_i.base_core) ? diff : '0;
                div_req_o.divisor  = stride_eff;
                state_d            = StDiv1;
              end
            end
            default: begin
              rr_d    = 1'b0;
              q_d     = '0;
              steps_d = '0;
              state_d = (n_eff == '0) ? StPush : StScan;
            end
          endcase
        end
      end
      StDiv1: begin
        // start index known, reduce it modulo the queue count
        if (div_rsp_i.done) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = div_rsp_i.quot;
          div_req_o.divisor  = lacqd_pkg::DivW'(n_eff);
          state_d            = StDiv2;
        end
      end
      StDiv2: begin
        if (div_rsp_i.done) begin
          q_d     = next_idx(div_rsp_i.rem[lacqd_pkg::QIdxW-1:0], n_eff);
          steps_d = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        if (hit) begin
          res_found_d = 1'b1;
          res_cpu_d   = cpu_full[lacqd_pkg::CpuW-1:0];
          state_d     = StPush;
        end else if (last_step) begin
          state_d = StPush;
        end else begin
          q_d     = next_idx(q_q, n_eff);
          steps_d = steps_q + 1'b1;
        end
      end
      StPush: begin
        if (!out_valid_q || out_ready_i) begin
          out_load_en = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    rr_q        <= rr_d;
    cur_q       <= cur_d;
    q_q         <= q_d;
    steps_q     <= steps_d;
    res_cpu_q   <= res_cpu_d;
    res_found_q <= res_found_d;
    res_load_q  <= res_load_d;
    res_under_q <= res_under_d;
    if (out_load_en) begin
      out_cpu_q   <= res_cpu_q;
      out_found_q <= res_found_q;
      out_load_q  <= res_load_q;
      out_under_q <= res_under_q;
    end
  end

  // outstanding-byte counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lacqd_pkg::MaxQueues; i++) begin
        load_mem_q[i] <= '0;
      end
    end else if (mem_we) begin
      load_mem_q[rd_addr] <= mem_wdata;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign chosen_cpu_o = out_cpu_q;
  assign found_o      = out_found_q;
  assign queue_load_o = out_load_q;
  assign underflow_o  = out_under_q;

  // a found pick never carries counter results
  a_found_is_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> (queue_load_o == '0) && !underflow_o)
    else $error("found result carries load or underflow");

  // divider answers only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> (state_q == StDiv1) || (state_q == StDiv2))
    else $error("divider done outside divide states");

  // scan never runs past the queues in use
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> ({1'b0, steps_q} < n_eff))
    else $error("scan step beyond queue count");

  // an accepted request always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != StIdle)
    else $error("accepted request did not start");

endmodule

>>> hdl/load_aware_copy_queue_dispatcher_top.sv
// Load-aware copy queue dispatcher: keeps a 32-bit outstanding-byte counter
// for each of 16 copy queues and answers one request at a time with one
// result. Enqueue and complete pass through the push state and the result
// register. A compact pick scans at most the queue count of queues, and a
// round-robin pick first uses the shared 8-step divider twice (cpu offset
// over stride, then start index modulo the queue count) and then scans; the
// scan reads one counter per cycle through a single read port. A new
// request is taken only when the sequencer is idle; the result register
// lets it be taken while the previous result still waits. Configuration
// registers at byte addresses 0 (base core), 4 (stride), 8 (queue count),
// 12 (threshold) must be written by the user only while no request is in
// flight; the block itself does not enforce this.
module load_aware_copy_queue_dispatcher_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lacqd_pkg::AddrW-1:0]  paddr,
  input  logic [lacqd_pkg::DataW-1:0]  pwdata,
  output logic [lacqd_pkg::DataW-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lacqd_pkg::CmdW-1:0]   command_i,
  input  logic [lacqd_pkg::CpuW-1:0]   last_cpu_i,
  input  logic [lacqd_pkg::CpuW-1:0]   current_cpu_i,
  input  logic [lacqd_pkg::QIdxW-1:0]  queue_index_i,
  input  logic [lacqd_pkg::BytesW-1:0] byte_count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lacqd_pkg::CpuW-1:0]   chosen_cpu_o,
  output logic                         found_o,
  output logic [lacqd_pkg::LoadW-1:0]  queue_load_o,
  output logic                         underflow_o
);

  lacqd_pkg::cfg_t     cfg;
  lacqd_pkg::div_req_t div_req;
  lacqd_pkg::div_rsp_t div_rsp;

  // configuration registers
  lacqd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // shared divider
  lacqd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer, counters and result register
  lacqd_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .last_cpu_i    (last_cpu_i),
    .current_cpu_i (current_cpu_i),
    .queue_index_i (queue_index_i),
    .byte_count_i  (byte_count_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .chosen_cpu_o  (chosen_cpu_o),
    .found_o       (found_o),
    .queue_load_o  (queue_load_o),
    .underflow_o   (underflow_o),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp)
  );

endmodule
